// File: src/lbrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// lbrc_pkg: types and constants of the light blink rate classifier
// Item and result structs, register indexes, operation codes, mode codes.
// -----------------------------------------------------------------------------
package lbrc_pkg;

	localparam int SAMPLE_BITS  = 12;
	localparam int TIMER_BITS   = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = (SAMPLE_BITS > TIMER_BITS) ? SAMPLE_BITS : TIMER_BITS;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_ON_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFF_THRESHOLD   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FAST_PERIOD_MIN = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FAST_PERIOD_MAX = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_PERIOD_MIN = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_PERIOD_MAX = 3'd5;

	// register reset values
	localparam logic [SAMPLE_BITS-1:0] ON_THRESHOLD_RST    = SAMPLE_BITS'(2048);
	localparam logic [SAMPLE_BITS-1:0] OFF_THRESHOLD_RST   = SAMPLE_BITS'(1024);
	localparam logic [TIMER_BITS-1:0]  FAST_PERIOD_MIN_RST = TIMER_BITS'(200);
	localparam logic [TIMER_BITS-1:0]  FAST_PERIOD_MAX_RST = TIMER_BITS'(600);
	localparam logic [TIMER_BITS-1:0]  SLOW_PERIOD_MIN_RST = TIMER_BITS'(800);
	localparam logic [TIMER_BITS-1:0]  SLOW_PERIOD_MAX_RST = TIMER_BITS'(1600);

	// item operation codes
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// reported blink state codes
	localparam logic [1:0] BLINK_OFF  = 2'd0;
	localparam logic [1:0] BLINK_FAST = 2'd1;
	localparam logic [1:0] BLINK_SLOW = 2'd2;
	localparam logic [1:0] BLINK_BAD  = 2'd3;

	// internal classifier mode
	typedef enum logic [3:0] {
		MODE_OFF  = 4'b0001,
		MODE_FAST = 4'b0010,
		MODE_SLOW = 4'b0100,
		MODE_EDGE = 4'b1000
	} mode_t;

	typedef struct packed {
		logic                   operation;
		logic [SAMPLE_BITS-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [1:0] blink_state;
		logic       light_is_on;
	} result_t;

endpackage
`default_nettype wire

// File: src/light_blink_rate_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// light_blink_rate_classifier_unit: blink rate classifier for a light sensor
// Counts ticks, thresholds samples with hysteresis and classifies the period
// between rising light edges as fast, slow or off blinking.
// -----------------------------------------------------------------------------
// The block takes one item per clock cycle while item_stall is low and returns
// one result per item: a beat lands in the input register, then the
// comparator, counter and classifier update the state and write the result
// register once that register is free. Both registers move together, so
// a full result register whose beat is taken in the same cycle does not stop
// a new item. Configuration writes are always ready and take effect at once;
// write them only while no item is in flight.
module light_blink_rate_classifier_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                item_valid,
	output logic                               item_stall,
	input  lbrc_pkg::item_t                    item,
	output logic                               result_valid,
	input  wire                                result_stall,
	output lbrc_pkg::result_t                  result,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [lbrc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire [lbrc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import lbrc_pkg::*;

	logic [SAMPLE_BITS-1:0] on_threshold_q;
	logic [SAMPLE_BITS-1:0] off_threshold_q;
	logic [TIMER_BITS-1:0]  fast_period_min_q;
	logic [TIMER_BITS-1:0]  fast_period_max_q;
	logic [TIMER_BITS-1:0]  slow_period_min_q;
	logic [TIMER_BITS-1:0]  slow_period_max_q;

	logic                   light_q;
	mode_t                  mode_q;
	logic [TIMER_BITS-1:0]  elapsed_q;

	logic                   valid_s1;
	item_t                  item_s1;

	logic                   result_free;
	logic                   advance;
	logic                   light_d;
	logic                   rising;
	logic                   timed_out;
	logic                   in_fast;
	logic                   in_slow;
	mode_t                  period_mode;
	mode_t                  mode_d;
	logic [TIMER_BITS-1:0]  elapsed_d;
	logic [1:0]             blink_d;

	// configuration port never waits
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_threshold_q    <= ON_THRESHOLD_RST;
			off_threshold_q   <= OFF_THRESHOLD_RST;
			fast_period_min_q <= FAST_PERIOD_MIN_RST;
			fast_period_max_q <= FAST_PERIOD_MAX_RST;
			slow_period_min_q <= SLOW_PERIOD_MIN_RST;
			slow_period_max_q <= SLOW_PERIOD_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ON_THRESHOLD:    on_threshold_q    <= cfg_data[SAMPLE_BITS-1:0];
				REG_OFF_THRESHOLD:   off_threshold_q   <= cfg_data[SAMPLE_BITS-1:0];
				REG_FAST_PERIOD_MIN: fast_period_min_q <= cfg_data[TIMER_BITS-1:0];
				REG_FAST_PERIOD_MAX: fast_period_max_q <= cfg_data[TIMER_BITS-1:0];
				REG_SLOW_PERIOD_MIN: slow_period_min_q <= cfg_data[TIMER_BITS-1:0];
				REG_SLOW_PERIOD_MAX: slow_period_max_q <= cfg_data[TIMER_BITS-1:0];
				default: ;
			endcase
		end
	end

	// handshake: the input register drains whenever the result register can load
	assign result_free = !result_valid || !result_stall;
	assign advance     = valid_s1 && result_free;
	assign item_stall  = valid_s1 && !result_free;

	// hold the accepted beat in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// hysteresis comparator: on wins when the thresholds overlap
	always_comb begin
		light_d = light_q;
		if (item_s1.sample >= on_threshold_q) begin
			light_d = 1'b1;
		end else if (item_s1.sample <= off_threshold_q) begin
			light_d = 1'b0;
		end
	end

	assign rising    = !light_q && light_d;
	assign timed_out = {1'b0, elapsed_q} >= {slow_period_max_q, 1'b0};
	assign in_fast   = (fast_period_min_q <= elapsed_q) && (elapsed_q <= fast_period_max_q);
	assign in_slow   = (slow_period_min_q <= elapsed_q) && (elapsed_q <= slow_period_max_q);

	// classify the period that just ended
	always_comb begin
		if (in_fast) begin
			period_mode = MODE_FAST;
		end else if (in_slow) begin
			period_mode = MODE_SLOW;
		end else begin
			period_mode = MODE_OFF;
		end
	end

	// advance counter and mode for this beat
	always_comb begin
		mode_d    = mode_q;
		elapsed_d = elapsed_q;
		if (item_s1.operation == OP_TICK) begin
			if (elapsed_q != '1) begin
				elapsed_d = elapsed_q + 1'b1;
			end
		end else if (mode_q == MODE_OFF) begin
			if (rising) begin
				elapsed_d = '0;
				mode_d    = MODE_EDGE;
			end
		end else if (rising) begin
			elapsed_d = '0;
			mode_d    = period_mode;
		end else if (timed_out) begin
			mode_d = MODE_OFF;
		end
	end

	// report the first-edge mode as off
	always_comb begin
		case (mode_d)
			MODE_FAST: blink_d = BLINK_FAST;
			MODE_SLOW: blink_d = BLINK_SLOW;
			default:   blink_d = BLINK_OFF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q   <= 1'b0;
			mode_q    <= MODE_OFF;
			elapsed_q <= '0;
		end else if (advance) begin
			if (item_s1.operation == OP_SAMPLE) begin
				light_q <= light_d;
			end
			mode_q    <= mode_d;
			elapsed_q <= elapsed_d;
		end
	end

	// load the result register, drop the beat once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (result_free) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.blink_state <= blink_d;
			result.light_is_on <= (item_s1.operation == OP_SAMPLE) ? light_d : light_q;
		end
	end

	// a tick counts up by one or stays saturated
	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.operation == OP_TICK) |=>
		(elapsed_q == $past(elapsed_q) + 1'b1) || ($past(elapsed_q) == '1))
		else $error("elapsed counter did not advance on a tick");

	// a rising light edge restarts the counter
	a_edge_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.operation == OP_SAMPLE && rising) |=> (elapsed_q == '0))
		else $error("elapsed counter not cleared on a rising edge");

	// a processed beat shows the comparator state it leaves behind
	a_result_light: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (result_valid && result.light_is_on == light_q))
		else $error("result light flag disagrees with the comparator");

	// the reserved blink code never leaves the block
	a_result_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.blink_state != BLINK_BAD))
		else $error("reserved blink state reported");

	// only a full input register behind a stalled full result register pushes back on the item side
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("item stall without a blocked result");

endmodule
`default_nettype wire

// File: bench/tb_light_blink_rate_classifier_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_light_blink_rate_classifier_unit: self-checking bench for the classifier
// Sends tick and sample beats through the item channel and programs the
// thresholds and period windows through the config channel. A behavioral
// model of the comparator, tick counter and period classifier predicts each
// result, and every result beat is compared field by field against it.
// -----------------------------------------------------------------------------
module tb_light_blink_rate_classifier_unit;
	import lbrc_pkg::*;

	localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
	localparam logic [TIMER_BITS-1:0] TICKS_FULL = '1;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     item_valid   = 1'b0;
	logic                     item_stall;
	item_t                    item         = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	result_t                  result;
	logic                     cfg_valid    = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data     = '0;

	light_blink_rate_classifier_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// model copy of the registers
	logic [SAMPLE_BITS-1:0] thr_on;
	logic [SAMPLE_BITS-1:0] thr_off;
	logic [TIMER_BITS-1:0]  fast_lo;
	logic [TIMER_BITS-1:0]  fast_hi;
	logic [TIMER_BITS-1:0]  slow_lo;
	logic [TIMER_BITS-1:0]  slow_hi;

	// model copy of the classifier state
	logic                   lamp_on;
	mode_t                  blink_mode;
	logic [TIMER_BITS-1:0]  ticks_since_edge;

	result_t expected_reports[$];
	result_t want_report;
	int      send_idle_pct   = 0;
	int      stall_pct       = 0;
	int      items_sent      = 0;
	int      reports_checked = 0;
	int      mismatches      = 0;
	int      settings_used   = 1;

	task automatic reset_model();
		thr_on           = ON_THRESHOLD_RST;
		thr_off          = OFF_THRESHOLD_RST;
		fast_lo          = FAST_PERIOD_MIN_RST;
		fast_hi          = FAST_PERIOD_MAX_RST;
		slow_lo          = SLOW_PERIOD_MIN_RST;
		slow_hi          = SLOW_PERIOD_MAX_RST;
		lamp_on          = 1'b0;
		blink_mode       = MODE_OFF;
		ticks_since_edge = '0;
	endtask

	function automatic mode_t period_mode(logic [TIMER_BITS-1:0] t);
		if (fast_lo <= t && t <= fast_hi)
			return MODE_FAST;
		if (slow_lo <= t && t <= slow_hi)
			return MODE_SLOW;
		return MODE_OFF;
	endfunction

	// advance the model by one item and return the state it reports
	function automatic result_t next_report(item_t it);
		logic                  was_on;
		logic                  rising;
		logic [TIMER_BITS-1:0] t;
		result_t               r;
		if (it.operation == OP_TICK) begin
			if (ticks_since_edge != TICKS_FULL)
				ticks_since_edge = ticks_since_edge + 1'b1;
		end else begin
			was_on = lamp_on;
			if (it.sample >= thr_on)
				lamp_on = 1'b1;
			else if (it.sample <= thr_off)
				lamp_on = 1'b0;
			rising = !was_on && lamp_on;
			t = ticks_since_edge;
			if (blink_mode == MODE_OFF) begin
				if (rising) begin
					ticks_since_edge = '0;
					blink_mode = MODE_EDGE;
				end
			end else if (rising) begin
				ticks_since_edge = '0;
				blink_mode = period_mode(t);
			end else if ({1'b0, t} >= {slow_hi, 1'b0}) begin
				// timeout at twice the slow maximum, compared one bit wider
				blink_mode = MODE_OFF;
			end
		end
		case (blink_mode)
			MODE_FAST: r.blink_state = BLINK_FAST;
			MODE_SLOW: r.blink_state = BLINK_SLOW;
			default:   r.blink_state = BLINK_OFF;
		endcase
		r.light_is_on = lamp_on;
		return r;
	endfunction

	// check each result beat and draw the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with nothing expected: state %0d light %0b",
						result.blink_state, result.light_is_on);
			end else begin
				want_report = expected_reports.pop_front();
				reports_checked++;
				if (result.blink_state !== want_report.blink_state ||
					result.light_is_on !== want_report.light_is_on) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: want state %0d light %0b, got state %0d light %0b",
							reports_checked, want_report.blink_state, want_report.light_is_on,
							result.blink_state, result.light_is_on);
				end
			end
		end
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// idle at random, then hold the beat until it is taken
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		expected_reports.push_back(next_report(it));
		items_sent++;
	endtask

	task automatic send_tick();
		item_t it;
		it.operation = OP_TICK;
		it.sample    = SAMPLE_BITS'($urandom);
		send_item(it);
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_tick();
	endtask

	task automatic send_sample(logic [SAMPLE_BITS-1:0] level);
		item_t it;
		it.operation = OP_SAMPLE;
		it.sample    = level;
		send_item(it);
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		item_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ON_THRESHOLD:    thr_on  = v[SAMPLE_BITS-1:0];
			REG_OFF_THRESHOLD:   thr_off = v[SAMPLE_BITS-1:0];
			REG_FAST_PERIOD_MIN: fast_lo = v[TIMER_BITS-1:0];
			REG_FAST_PERIOD_MAX: fast_hi = v[TIMER_BITS-1:0];
			REG_SLOW_PERIOD_MIN: slow_lo = v[TIMER_BITS-1:0];
			REG_SLOW_PERIOD_MAX: slow_hi = v[TIMER_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [CFG_DATA_BITS-1:0] on_v, logic [CFG_DATA_BITS-1:0] off_v,
		logic [CFG_DATA_BITS-1:0] flo, logic [CFG_DATA_BITS-1:0] fhi,
		logic [CFG_DATA_BITS-1:0] slo, logic [CFG_DATA_BITS-1:0] shi);
		settle();
		write_reg(REG_ON_THRESHOLD, on_v);
		write_reg(REG_OFF_THRESHOLD, off_v);
		write_reg(REG_FAST_PERIOD_MIN, flo);
		write_reg(REG_FAST_PERIOD_MAX, fhi);
		write_reg(REG_SLOW_PERIOD_MIN, slo);
		write_reg(REG_SLOW_PERIOD_MAX, shi);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// sample levels relative to the current thresholds
	function automatic logic [SAMPLE_BITS-1:0] lit_level();
		return SAMPLE_BITS'($urandom_range(SAMPLE_MAX, int'(thr_on)));
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] dark_level();
		int hi;
		if (thr_on == 0)
			return '0;
		hi = (thr_off < thr_on) ? int'(thr_off) : int'(thr_on) - 1;
		return SAMPLE_BITS'($urandom_range(hi, 0));
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] hold_level();
		if (int'(thr_on) > int'(thr_off) + 1)
			return SAMPLE_BITS'($urandom_range(int'(thr_on) - 1, int'(thr_off) + 1));
		return lamp_on ? lit_level() : dark_level();
	endfunction

	// period biased toward the windows and the timeout boundary
	function automatic int pick_period();
		int r;
		r = $urandom_range(99);
		if (r < 35 && fast_lo <= fast_hi)
			return $urandom_range(int'(fast_hi), int'(fast_lo));
		if (r < 70 && slow_lo <= slow_hi)
			return $urandom_range(int'(slow_hi), int'(slow_lo));
		if (r < 85)
			return $urandom_range(2 * int'(slow_hi) + 1, (slow_hi == 0) ? 0 : 2 * int'(slow_hi) - 1);
		return $urandom_range(2 * int'(slow_hi) + 3, 0);
	endfunction

	task automatic pad_ticks(int n);
		repeat (n) begin
			send_tick();
			if ($urandom_range(99) < 15)
				send_sample(hold_level());
		end
	endtask

	// one light pulse: lit sample, ticks, a dark sample in most pulses, ticks up to the period
	task automatic blink_cycle(int period);
		int k;
		send_sample(lit_level());
		k = $urandom_range(period, 0);
		pad_ticks(k);
		if ($urandom_range(9) != 0)
			send_sample(dark_level());
		pad_ticks(period - k);
	endtask

	// small random windows keep periods short; thresholds carry junk upper bits
	task automatic random_config();
		logic [CFG_DATA_BITS-1:0] on_w;
		logic [CFG_DATA_BITS-1:0] off_w;
		int on_v;
		int flo;
		int fhi;
		int slo;
		int shi;
		on_v = $urandom_range(SAMPLE_MAX, 1);
		on_w = CFG_DATA_BITS'($urandom);
		off_w = CFG_DATA_BITS'($urandom);
		on_w[SAMPLE_BITS-1:0] = SAMPLE_BITS'(on_v);
		if ($urandom_range(9) == 0)
			off_w[SAMPLE_BITS-1:0] = SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0));
		else
			off_w[SAMPLE_BITS-1:0] = SAMPLE_BITS'($urandom_range(on_v - 1, 0));
		fhi = $urandom_range(10, 0);
		flo = ($urandom_range(9) == 0) ? fhi + $urandom_range(3, 1) : $urandom_range(fhi, 0);
		shi = $urandom_range(20, 2);
		slo = ($urandom_range(9) == 0) ? shi + $urandom_range(3, 1) : $urandom_range(shi, 0);
		configure(on_w, off_w, CFG_DATA_BITS'(flo), CFG_DATA_BITS'(fhi),
			CFG_DATA_BITS'(slo), CFG_DATA_BITS'(shi));
	endtask

	task automatic test_default_windows();
		// periods on the lower bounds of the reset windows
		send_sample(2047);
		send_sample(2048);
		send_ticks(200);
		send_sample(1024);
		send_sample(1025);
		send_sample(4095);
		send_ticks(800);
		send_sample(0);
		send_sample(2048);
	endtask

	task automatic test_thresholds();
		// extreme thresholds, junk in the upper data bits
		configure(16'hFFFF, 16'hF000, 0, 16'hFFFF, 0, 16'hFFFF);
		send_sample(4094);
		send_sample(4095);
		send_sample(1);
		send_sample(0);
		send_sample(4095);
		// on at zero: every level counts as on
		configure(0, 16'h0FFF, 0, 16'hFFFF, 0, 16'hFFFF);
		send_sample(0);
		send_sample(4095);
		// equal thresholds
		configure(3000, 3000, 0, 16'hFFFF, 0, 16'hFFFF);
		send_sample(2999);
		send_sample(3000);
		send_sample(3001);
		// overlapping thresholds: on wins
		configure(1000, 3000, 0, 16'hFFFF, 0, 16'hFFFF);
		send_sample(999);
		send_sample(2000);
		send_sample(3500);
		send_sample(999);
	endtask

	task automatic test_period_windows();
		configure(2048, 1024, 2, 3, 5, 6);
		send_sample(0);
		send_sample(4095);
		send_ticks(2);
		send_sample(0);
		send_sample(4095);
		send_ticks(4);
		send_sample(0);
		send_sample(4095);
		send_sample(0);
		send_sample(4095);
		send_ticks(6);
		send_sample(0);
		send_sample(4095);
		// timeout lands exactly at twice the slow maximum
		send_ticks(11);
		send_sample(0);
		send_tick();
		send_sample(1500);
		// both windows empty
		configure(2048, 1024, 9, 8, 8, 7);
		send_sample(4095);
		send_ticks(8);
		send_sample(0);
		send_sample(4095);
		// zero slow maximum: any plain sample times out
		configure(2048, 1024, 9, 8, 1, 0);
		send_sample(0);
		send_sample(4095);
		send_sample(1500);
	endtask

	task automatic test_random_traffic(int n_items);
		int target;
		repeat (3) begin
			random_config();
			target = items_sent + n_items / 3;
			while (items_sent < target) begin
				if ($urandom_range(99) < 75) begin
					blink_cycle(pick_period());
				end else begin
					repeat ($urandom_range(6, 1)) begin
						if ($urandom_range(1))
							send_sample(SAMPLE_BITS'($urandom));
						else
							send_tick();
					end
				end
			end
		end
	endtask

	initial begin
		reset_model();
		send_idle_pct = 30;
		stall_pct     = 55;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_default_windows();
		test_thresholds();
		test_period_windows();
		test_random_traffic(100);

		send_idle_pct = 55;
		stall_pct     = 30;
		test_random_traffic(100);

		send_idle_pct = 0;
		stall_pct     = 0;
		test_random_traffic(100);

		settle();
		repeat (10) @(posedge clk);
		$display("Ran %0d items over %0d register settings; %0d results compared, %0d bad.",
			items_sent, settings_used, reports_checked, mismatches);
		$display("Traffic mixed threshold and window corners, timeout edges and idle mixes.");
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("** light_blink_rate_classifier_unit: PASSED **");
		else
			$display("** light_blink_rate_classifier_unit: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#200_000;
		$display("timeout with %0d results outstanding", expected_reports.size());
		$display("** light_blink_rate_classifier_unit: FAILED **");
		$finish;
	end

endmodule
